// File: hdl/majority_vote_verify_assert.svh
// ----------------------------------------------------------------------------
// majority_vote_verify assertion macros
// shared property forms for the checker of the majority vote block
// ----------------------------------------------------------------------------
`ifndef MAJORITY_VOTE_VERIFY_ASSERT_SVH
`define MAJORITY_VOTE_VERIFY_ASSERT_SVH

// same-cycle implication, disabled during reset
`define MVV_ASSERT_IMPL(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, disabled during reset
`define MVV_ASSERT_NEXT(name, clk, rstn, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

// next-cycle implication, also checked across reset
`define MVV_ASSERT_NEXT_RAW(name, clk, ante, cons) \
    name: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

// File: hdl/mvv_pkg.sv
// ----------------------------------------------------------------------------
// mvv_pkg
// types and constants shared by the majority vote verify block
// ----------------------------------------------------------------------------
package mvv_pkg;

    localparam int MAX_ITEMS = 1024;
    localparam int IDX_W     = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CNT_W     = $clog2(MAX_ITEMS + 1);
    localparam int ADDR_W    = IDX_W + 1;
    localparam int RAM_DEPTH = 2 ** ADDR_W;
    localparam int DATA_W    = 32;

    typedef struct packed {
        logic signed [DATA_W-1:0] value;
        logic                     last;
    } in_item_t;

    typedef struct packed {
        logic                     found;
        logic signed [DATA_W-1:0] majority;
        logic                     overflow;
    } result_t;

    typedef struct packed {
        logic                     bank;
        logic signed [DATA_W-1:0] candidate;
        logic [CNT_W-1:0]         count;
        logic                     overflow;
    } job_t;

    typedef struct packed {
        logic valid;
        logic bank;
    } bank_release_t;

endpackage

// File: hdl/mvv_ram.sv
// ----------------------------------------------------------------------------
// mvv_ram
// generic simple dual-port ram with registered read
// ----------------------------------------------------------------------------
module mvv_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// File: hdl/mvv_queue.sv
// ----------------------------------------------------------------------------
// mvv_queue
// two-entry job queue between the loader and the verifier
// ----------------------------------------------------------------------------
module mvv_queue
    import mvv_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  job_t push_job,
    output logic full,
    input  logic pop,
    output job_t pop_job,
    output logic empty
);

    job_t       mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_push, do_pop;

    assign full    = (cnt_reg == 2'd2);
    assign empty   = (cnt_reg == 2'd0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign pop_job = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        cnt_next    = cnt_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hdl/mvv_front.sv
// ----------------------------------------------------------------------------
// mvv_front
// loader: stores elements into a ram bank and runs the vote
// ----------------------------------------------------------------------------
module mvv_front
    import mvv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  in_item_t          s_data,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output logic [DATA_W-1:0] wr_data,
    output logic              job_push,
    output job_t              job,
    input  logic              job_full,
    input  bank_release_t     release_in
);

    logic signed [DATA_W-1:0] cand_reg, cand_next;
    logic [CNT_W-1:0]         vote_reg, vote_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     ovf_reg, ovf_next;
    logic                     bank_reg, bank_next;
    logic [1:0]               busy_reg, busy_next;
    logic                     accept, keep;

    assign s_ready = !busy_reg[bank_reg] && !job_full;
    assign accept  = s_valid && s_ready;
    assign keep    = (cnt_reg < CNT_W'(MAX_ITEMS));

    assign wr_en   = accept && keep;
    assign wr_addr = {bank_reg, cnt_reg[IDX_W-1:0]};
    assign wr_data = s_data.value;

    always_comb begin
        cand_next = cand_reg;
        vote_next = vote_reg;
        cnt_next  = cnt_reg;
        ovf_next  = ovf_reg;
        bank_next = bank_reg;
        busy_next = busy_reg;
        job_push  = 1'b0;
        job       = '0;

        if (release_in.valid) begin
            busy_next[release_in.bank] = 1'b0;
        end

        if (accept) begin
            if (keep) begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (vote_reg == '0) begin
                    cand_next = s_data.value;
                    vote_next = CNT_W'(1);
                end else if (s_data.value == cand_reg) begin
                    vote_next = vote_reg + CNT_W'(1);
                end else begin
                    vote_next = vote_reg - CNT_W'(1);
                end
            end else begin
                ovf_next = 1'b1;
            end

            if (s_data.last) begin
                job_push            = 1'b1;
                job.bank            = bank_reg;
                job.candidate       = cand_next;
                job.count           = cnt_next;
                job.overflow        = ovf_next;
                busy_next[bank_reg] = 1'b1;
                bank_next           = !bank_reg;
                cand_next           = '0;
                vote_next           = '0;
                cnt_next            = '0;
                ovf_next            = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cand_reg <= '0;
            vote_reg <= '0;
            cnt_reg  <= '0;
            ovf_reg  <= 1'b0;
            bank_reg <= 1'b0;
            busy_reg <= '0;
        end else begin
            cand_reg <= cand_next;
            vote_reg <= vote_next;
            cnt_reg  <= cnt_next;
            ovf_reg  <= ovf_next;
            bank_reg <= bank_next;
            busy_reg <= busy_next;
        end
    end

endmodule

// File: hdl/mvv_back.sv
// ----------------------------------------------------------------------------
// mvv_back
// verifier: sweeps a stored bank, counts candidate matches, emits result
// ----------------------------------------------------------------------------
module mvv_back
    import mvv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_avail,
    input  job_t              job_in,
    output logic              job_pop,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  logic [DATA_W-1:0] rd_data,
    output bank_release_t     release_out,
    output logic              m_valid,
    input  logic              m_ready,
    output result_t           m_data
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SWEEP = 4'b0010,
        ST_TAIL  = 4'b0100,
        ST_FIN   = 4'b1000
    } state_t;

    state_t           state_reg, state_next;
    job_t             job_reg, job_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [CNT_W-1:0] match_reg, match_next;
    logic             rvalid_reg, rvalid_next;
    logic             m_valid_reg, m_valid_next;
    result_t          m_data_reg, m_data_next;
    logic             out_free;
    logic             last_idx;

    assign out_free = !m_valid_reg || m_ready;
    assign last_idx = (CNT_W'(idx_reg) == job_reg.count - CNT_W'(1));
    assign rd_addr  = {job_reg.bank, idx_reg};
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    always_comb begin
        state_next       = state_reg;
        job_next         = job_reg;
        idx_next         = idx_reg;
        match_next       = match_reg;
        rvalid_next      = 1'b0;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_next      = m_data_reg;
        job_pop          = 1'b0;
        rd_en            = 1'b0;
        release_out      = '0;

        if (rvalid_reg && (rd_data == job_reg.candidate)) begin
            match_next = match_reg + CNT_W'(1);
        end

        case (state_reg)
            ST_IDLE: begin
                if (job_avail) begin
                    job_pop    = 1'b1;
                    job_next   = job_in;
                    idx_next   = '0;
                    match_next = '0;
                    state_next = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                rd_en       = 1'b1;
                rvalid_next = 1'b1;
                if (last_idx) begin
                    state_next = ST_TAIL;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            ST_TAIL: begin
                release_out.valid = 1'b1;
                release_out.bank  = job_reg.bank;
                state_next        = ST_FIN;
            end
            ST_FIN: begin
                if (out_free) begin
                    m_valid_next         = 1'b1;
                    m_data_next.found    = (match_reg > (job_reg.count >> 1));
                    m_data_next.majority = job_reg.candidate;
                    m_data_next.overflow = job_reg.overflow;
                    state_next           = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            rvalid_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            rvalid_reg  <= rvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        job_reg    <= job_next;
        idx_reg    <= idx_next;
        match_reg  <= match_next;
        m_data_reg <= m_data_next;
    end

endmodule

// File: hdl/majority_vote_verify.sv
// ----------------------------------------------------------------------------
// majority_vote_verify
// boyer-moore majority vote over a sequence with a verify pass
// ----------------------------------------------------------------------------
// s_ channel: one signed element per transaction, last flags the final one.
// m_ channel: one result per sequence with found, majority and overflow.
// elements beyond MAX_ITEMS in a sequence are dropped and set overflow.
// loading takes one element per cycle while s_ready is high; the vote runs as elements arrive.
// the verify pass reads the stored bank through the ram read port, one
// element per cycle in the sweep state, counts matches from the registered
// read data, releases the bank in tail and loads the result register in fin.
// the ram holds two banks: the next sequence loads while the previous one
// is verified, and s_ready drops only when both banks wait for verify.
// a stalled receiver holds the result in the output register; verify of
// the next sequence runs up to that register and then waits.
// synchronous reset clears all control state and drops both valids; no
// clearing pass is needed.
// ----------------------------------------------------------------------------
module majority_vote_verify
    import mvv_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output result_t  m_data
);

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic              job_push;
    job_t              push_job;
    logic              job_full;
    logic              job_pop;
    job_t              pop_job;
    logic              job_empty;
    bank_release_t     bank_release;

    mvv_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .job_push   (job_push),
        .job        (push_job),
        .job_full   (job_full),
        .release_in (bank_release)
    );

    mvv_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (job_push),
        .push_job (push_job),
        .full     (job_full),
        .pop      (job_pop),
        .pop_job  (pop_job),
        .empty    (job_empty)
    );

    mvv_ram #(
        .WIDTH (DATA_W),
        .DEPTH (RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    mvv_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_avail   (!job_empty),
        .job_in      (pop_job),
        .job_pop     (job_pop),
        .rd_en       (rd_en),
        .rd_addr     (rd_addr),
        .rd_data     (rd_data),
        .release_out (bank_release),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

// File: hdl/mvv_checker.sv
// ----------------------------------------------------------------------------
// mvv_checker
// port-level checks for the majority vote verify block
// ----------------------------------------------------------------------------
`include "majority_vote_verify_assert.svh"

module mvv_checker
    import mvv_pkg::*;
(
    input logic     aclk,
    input logic     aresetn,
    input logic     s_valid,
    input logic     s_ready,
    input in_item_t s_data,
    input logic     m_valid,
    input logic     m_ready,
    input result_t  m_data
);

    logic [3:0] pend_reg, pend_next;
    logic       seq_done, res_taken;

    assign seq_done  = s_valid && s_ready && s_data.last;
    assign res_taken = m_valid && m_ready;

    always_comb begin
        pend_next = pend_reg + 4'(seq_done) - 4'(res_taken);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg <= '0;
        end else begin
            pend_reg <= pend_next;
        end
    end

    // results only for closed sequences
    `MVV_ASSERT_IMPL(a_result_has_sequence, aclk, aresetn, m_valid, pend_reg != 4'd0)

    // stalled result holds
    `MVV_ASSERT_NEXT(a_result_holds, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // reset drops the result channel
    `MVV_ASSERT_NEXT_RAW(a_reset_clears, aclk, !aresetn, !m_valid)

endmodule

bind majority_vote_verify mvv_checker u_checker (.*);
